FILE: rtl/chained_byte_shift_cipher_assert.svh
// Assertion macros for the chained byte-shift cipher.
// Included by modules that check their own control logic; needs clk and arst_n in scope.
`ifndef CHAINED_BYTE_SHIFT_CIPHER_ASSERT_SVH
`define CHAINED_BYTE_SHIFT_CIPHER_ASSERT_SVH

// Same-cycle implication, off during reset.
`define CBSC_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cbsc implication check failed");

// Next-cycle implication, off during reset.
`define CBSC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cbsc next-cycle check failed");

`endif

FILE: rtl/cbsc_pkg.sv
// Shared types and constants of the chained byte-shift cipher.
// No dependencies; used by every module of the block.
package cbsc_pkg;

	localparam int KEY_CAP           = 16;
	localparam int KEY_CAP_W         = $clog2(KEY_CAP + 1);
	localparam int IDX_W             = $clog2(KEY_CAP);
	localparam int MAX_KEY_BYTES_DEF = 16;
	localparam int TOTAL_W           = 13;
	localparam int DIV_W             = 9;
	localparam int REM_W             = 8;
	localparam int SALT_W            = 5;
	localparam int SALT_MOD          = 25;
	localparam int SALT_RECIP        = 41;
	localparam int SALT_SHIFT        = 10;
	localparam int FIFO_DEPTH        = 4;
	localparam int APB_DATA_W        = 64;
	localparam int CFG_ADDR_W        = 6;

	localparam logic [2:0] REG_KEY_LO   = 3'd0;
	localparam logic [2:0] REG_KEY_HI   = 3'd1;
	localparam logic [2:0] REG_KEY_LEN  = 3'd2;
	localparam logic [2:0] REG_DEC_MODE = 3'd3;
	localparam logic [2:0] REG_SALT_EN  = 3'd4;

	typedef enum logic {
		CMD_START = 1'b0,
		CMD_DATA  = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_MOD_START,
		ST_MOD_WAIT,
		ST_START_OUT,
		ST_OUT,
		ST_MARK
	} back_state_t;

	typedef struct packed {
		cmd_t       kind;
		logic [7:0] data;
		logic       fin;
	} in_item_t;

	typedef struct packed {
		logic [7:0]        out_byte;
		logic              run_end;
		logic              message_end;
		logic [SALT_W-1:0] salt_count;
		logic              short_error;
	} out_item_t;

	typedef struct packed {
		logic [63:0]          key_lo;
		logic [63:0]          key_hi;
		logic [KEY_CAP_W-1:0] key_len;
		logic                 dec_mode;
		logic                 salt_en;
	} cfg_t;

	typedef struct packed {
		logic               start;
		logic [TOTAL_W-1:0] dividend;
		logic [DIV_W-1:0]   divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [REM_W-1:0] rem;
	} div_rsp_t;

endpackage

FILE: rtl/cbsc_front.sv
// Input side of the cipher: accepts stream items, classifies them and queues them.
// Depends on cbsc_pkg.
module cbsc_front import cbsc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic     s_tuser,     // [0] cmd
	input  logic     s_tlast,
	output logic     q_valid,
	output in_item_t q_item,
	input  logic     q_pop
);
	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	in_item_t         fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	in_item_t         item_in;

	assign s_tready = (count_q != CNT_W'(FIFO_DEPTH));
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (count_q != '0);
	assign q_item   = fifo_q[rd_ptr_q];

	always_comb begin
		item_in.kind = cmd_t'(s_tuser);
		item_in.data = s_tdata;
		item_in.fin  = s_tlast;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, q_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule

FILE: rtl/cbsc_mod_unit.sv
// Bit-serial remainder unit: one remainder bit per cycle, stepping through all TOTAL_W dividend bits.
// Depends on cbsc_pkg.
module cbsc_mod_unit import cbsc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	localparam int CNT_W = $clog2(TOTAL_W + 1);

	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q, done_q;
	logic [TOTAL_W-1:0] dvd_q;
	logic [DIV_W-1:0]   dsr_q;
	logic [DIV_W-1:0]   rem_q;
	logic [DIV_W:0]     trial;
	logic [DIV_W:0]     rem_next;

	always_comb begin
		trial    = {rem_q, dvd_q[TOTAL_W-1]};
		rem_next = (trial >= {1'b0, dsr_q}) ? trial - {1'b0, dsr_q} : trial;
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[TOTAL_W-2:0], 1'b0};
			rem_q <= rem_next[DIV_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q  <= CNT_W'(TOTAL_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.rem  = rem_q[REM_W-1:0];
endmodule

FILE: rtl/cbsc_back.sv
// Execution side of the cipher: key shift derivation, block shifting, chaining and results.
// Depends on cbsc_pkg, cbsc_mod_unit (through div_req/div_rsp) and the assertion header.
`include "chained_byte_shift_cipher_assert.svh"
module cbsc_back import cbsc_pkg::*; #(
	parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      q_valid,
	input  in_item_t  q_item,
	output logic      q_pop,
	output div_req_t  div_req,
	input  div_rsp_t  div_rsp,
	input  logic      m_tready,
	output logic      m_tvalid,
	output out_item_t m_item
);
	localparam int CAP = (MAX_KEY_BYTES < KEY_CAP) ? MAX_KEY_BYTES : KEY_CAP;

	back_state_t          state_q, state_d;
	logic [7:0]           buf_q   [KEY_CAP];
	logic [7:0]           src_q   [KEY_CAP];
	logic [7:0]           chain_q [KEY_CAP];
	logic [7:0]           key_sh_q[KEY_CAP];
	logic [IDX_W-1:0]     idx_q;
	logic [KEY_CAP_W-1:0] n_q, blk_len_q, fill_q;
	logic [TOTAL_W-1:0]   total_q;
	logic                 to_key_q, dec_q, fin_q, emitted_q, mark_q, zero_seen_q;
	logic [SALT_W-1:0]    salt_q, salt_left_q, salt_acc_q;
	logic                 out_valid_q;
	out_item_t            out_q;

	logic                 idx_last, slot_free, drop, step_ok, mark_now, blk_done, out_load;
	logic [7:0]           buf_b, ch, ks, enc_c, out_v, cipher;
	logic [KEY_CAP_W-1:0] len_clamped, fill_next;
	logic [127:0]         key_all;
	logic [8:0]           salt_x;
	logic [13:0]          salt_prod;
	logic [8:0]           salt_r;
	logic [SALT_W-1:0]    salt_mod, acc_next;
	out_item_t            out_d;

	always_comb begin
		idx_last  = ({1'b0, idx_q} == n_q - 1'b1);
		slot_free = !out_valid_q || m_tready;
		buf_b     = buf_q[idx_q];
		ch        = chain_q[idx_q];
		ks        = key_sh_q[idx_q];
		enc_c     = buf_b + ch;
		out_v     = dec_q ? (buf_b - ch) : enc_c;
		cipher    = dec_q ? buf_b : enc_c;
		drop      = dec_q && (salt_left_q != '0);
		mark_now  = fin_q && !emitted_q && drop;
		fill_next = fill_q + 1'b1;
		blk_done  = (fill_next == blk_len_q) || q_item.fin;
		key_all   = {cfg.key_hi, cfg.key_lo};
		if (cfg.key_len == '0) begin
			len_clamped = KEY_CAP_W'(1);
		end else if (cfg.key_len > KEY_CAP_W'(CAP)) begin
			len_clamped = KEY_CAP_W'(CAP);
		end else begin
			len_clamped = cfg.key_len;
		end
		// Running salt sum mod 25 via reciprocal multiply and one correction.
		salt_x    = {4'b0, salt_acc_q} + {1'b0, div_rsp.rem};
		salt_prod = salt_x * 14'(SALT_RECIP);
		salt_r    = salt_x - 9'(salt_prod >> SALT_SHIFT) * 9'(SALT_MOD);
		salt_mod  = (salt_r >= 9'(SALT_MOD)) ? SALT_W'(salt_r - 9'(SALT_MOD))
			: SALT_W'(salt_r);
		acc_next  = (zero_seen_q || div_rsp.rem == '0) ? salt_acc_q : salt_mod;
	end

	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		div_req  = '0;
		out_load = 1'b0;
		out_d    = '0;
		step_ok  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					if (q_item.kind == CMD_START) begin
						state_d = ST_SUM;
					end else if (blk_done) begin
						state_d = ST_OUT;
					end
				end
			end
			ST_SUM: begin
				if (idx_last) begin
					state_d = ST_MOD_START;
				end
			end
			ST_MOD_START: begin
				div_req.start    = 1'b1;
				div_req.dividend = total_q;
				div_req.divisor  = {1'b0, src_q[idx_q]} + 1'b1;
				state_d          = ST_MOD_WAIT;
			end
			ST_MOD_WAIT: begin
				if (div_rsp.done) begin
					if (!idx_last) begin
						state_d = ST_MOD_START;
					end else if (to_key_q) begin
						state_d = ST_START_OUT;
					end else begin
						state_d = mark_q ? ST_MARK : ST_IDLE;
					end
				end
			end
			ST_START_OUT: begin
				if (slot_free) begin
					out_load          = 1'b1;
					out_d.run_end     = 1'b1;
					out_d.salt_count  = salt_q;
					state_d           = ST_IDLE;
				end
			end
			ST_OUT: begin
				step_ok = drop || slot_free;
				if (!drop && slot_free) begin
					out_load          = 1'b1;
					out_d.out_byte    = out_v;
					out_d.run_end     = idx_last;
					out_d.message_end = idx_last && fin_q;
					out_d.salt_count  = salt_q;
				end
				if (step_ok && idx_last) begin
					if (n_q == blk_len_q) begin
						state_d = ST_SUM;
					end else begin
						state_d = mark_now ? ST_MARK : ST_IDLE;
					end
				end
			end
			ST_MARK: begin
				if (slot_free) begin
					out_load          = 1'b1;
					out_d.run_end     = 1'b1;
					out_d.message_end = 1'b1;
					out_d.salt_count  = salt_q;
					out_d.short_error = (salt_left_q != '0);
					state_d           = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Payload stores: block bytes, derivation source and the output item, no reset.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_pop) begin
			if (q_item.kind == CMD_START) begin
				for (int i = 0; i < KEY_CAP; i++) begin
					src_q[i] <= key_all[8*i +: 8];
				end
			end else begin
				buf_q[fill_q[IDX_W-1:0]] <= q_item.data;
			end
		end
		if (state_q == ST_OUT && step_ok) begin
			src_q[idx_q] <= cipher + ks;
		end
		if (out_load) begin
			out_q <= out_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			n_q         <= KEY_CAP_W'(1);
			blk_len_q   <= KEY_CAP_W'(1);
			fill_q      <= '0;
			total_q     <= '0;
			to_key_q    <= 1'b0;
			dec_q       <= 1'b0;
			fin_q       <= 1'b0;
			emitted_q   <= 1'b0;
			mark_q      <= 1'b0;
			zero_seen_q <= 1'b0;
			salt_q      <= '0;
			salt_left_q <= '0;
			salt_acc_q  <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < KEY_CAP; i++) begin
				chain_q[i]  <= '0;
				key_sh_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						if (q_item.kind == CMD_START) begin
							n_q         <= len_clamped;
							blk_len_q   <= len_clamped;
							dec_q       <= cfg.dec_mode;
							to_key_q    <= 1'b1;
							total_q     <= '0;
							idx_q       <= '0;
							salt_acc_q  <= '0;
							zero_seen_q <= 1'b0;
							fill_q      <= '0;
							mark_q      <= 1'b0;
						end else if (blk_done) begin
							n_q       <= fill_next;
							fin_q     <= q_item.fin;
							emitted_q <= 1'b0;
							idx_q     <= '0;
							fill_q    <= '0;
						end else begin
							fill_q <= fill_next;
						end
					end
				end
				ST_SUM: begin
					total_q <= total_q + (idx_q[0] ? TOTAL_W'({src_q[idx_q], 1'b0})
						: TOTAL_W'(src_q[idx_q]));
					idx_q   <= idx_last ? '0 : idx_q + 1'b1;
				end
				ST_MOD_WAIT: begin
					if (div_rsp.done) begin
						chain_q[idx_q] <= div_rsp.rem;
						if (to_key_q) begin
							key_sh_q[idx_q] <= div_rsp.rem;
							salt_acc_q      <= acc_next;
							zero_seen_q     <= zero_seen_q || (div_rsp.rem == '0);
							if (idx_last) begin
								salt_q      <= cfg.salt_en ? acc_next : '0;
								salt_left_q <= cfg.salt_en ? acc_next : '0;
							end
						end
						idx_q <= idx_last ? '0 : idx_q + 1'b1;
					end
				end
				ST_OUT: begin
					if (step_ok) begin
						if (drop) begin
							salt_left_q <= salt_left_q - 1'b1;
						end else begin
							emitted_q <= 1'b1;
						end
						if (idx_last) begin
							mark_q   <= mark_now;
							to_key_q <= 1'b0;
							total_q  <= '0;
							idx_q    <= '0;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_item   = out_q;

	`CBSC_ASSERT_IMPL(a_pop_idle, q_pop, state_q == ST_IDLE)
	`CBSC_ASSERT_IMPL(a_div_free, div_req.start, !div_rsp.busy)
	`CBSC_ASSERT_IMPL(a_load_free, out_load, !out_valid_q || m_tready)
	`CBSC_ASSERT_IMPL(a_salt_range, 1'b1, salt_acc_q < SALT_W'(SALT_MOD))
	`CBSC_ASSERT_NEXT(a_fill_bound, state_q == ST_IDLE, fill_q < blk_len_q)
endmodule

FILE: rtl/chained_byte_shift_cipher.sv
// Chained byte-shift cipher. Start for key length N: accept, a sum pass over the N key bytes,
// one remainder operation per key byte in the bit-serial remainder unit (13 bits, one per cycle),
// then the start result. Full block of N bytes: accept, shift, sum and one remainder per byte;
// a short final block takes only its accept and shift steps, plus a closing mark if it sent no byte.
// Remainder unit sets the rate. A 4-item input queue and one output register decouple sides.
// Reset (arst_n low, async): queue empty, shifts zero, block length 1, encrypt, salt 0.
module chained_byte_shift_cipher import cbsc_pkg::*; #(
	parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Input item stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // [7:0] data_byte
	input  logic                  s_tuser,   // [0] cmd (0 start, 1 data)
	input  logic                  s_tlast,   // final_byte
	// Result item stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [15:0]           m_tdata,   // [7:0] out_byte, [8] message_end,
	                                         // [13:9] salt_count, [14] short_error, [15] 0
	output logic                  m_tlast,   // run_end
	// Register port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);
	cfg_t      cfg_q;
	logic      cfg_wr;
	logic [2:0] reg_idx;
	logic      q_valid, q_pop;
	in_item_t  q_item;
	div_req_t  div_req;
	div_rsp_t  div_rsp;
	out_item_t m_item;

	// Registers sit on 8-byte strides; write in the access phase.
	assign pready  = 1'b1;
	assign reg_idx = paddr[CFG_ADDR_W-1:3];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.key_lo   <= '0;
			cfg_q.key_hi   <= '0;
			cfg_q.key_len  <= KEY_CAP_W'(1);
			cfg_q.dec_mode <= 1'b0;
			cfg_q.salt_en  <= 1'b1;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_KEY_LO:   cfg_q.key_lo   <= pwdata;
				REG_KEY_HI:   cfg_q.key_hi   <= pwdata;
				REG_KEY_LEN:  cfg_q.key_len  <= pwdata[KEY_CAP_W-1:0];
				REG_DEC_MODE: cfg_q.dec_mode <= pwdata[0];
				REG_SALT_EN:  cfg_q.salt_en  <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	// Read back the register at the addressed slot; unused slots read zero.
	always_comb begin
		case (reg_idx)
			REG_KEY_LO:   prdata = cfg_q.key_lo;
			REG_KEY_HI:   prdata = cfg_q.key_hi;
			REG_KEY_LEN:  prdata = APB_DATA_W'(cfg_q.key_len);
			REG_DEC_MODE: prdata = APB_DATA_W'(cfg_q.dec_mode);
			REG_SALT_EN:  prdata = APB_DATA_W'(cfg_q.salt_en);
			default:      prdata = '0;
		endcase
	end

	// Front: accept and classify items, hold them in the queue.
	cbsc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	// Shared remainder unit for key and chain shift derivation.
	cbsc_mod_unit u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Back: derive shifts, shift blocks, drop salt, drive results.
	cbsc_back #(
		.MAX_KEY_BYTES (MAX_KEY_BYTES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop),
		.div_req  (div_req),
		.div_rsp  (div_rsp),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_item   (m_item)
	);

	// Pack result fields from the lowest bit up.
	assign m_tdata = {1'b0, m_item.short_error, m_item.salt_count, m_item.message_end,
		m_item.out_byte};
	assign m_tlast = m_item.run_end;
endmodule
